FILE: rtl/core/gpfw_pkg.sv
// Shared types, codes and constants of the glyph page framebuffer writer.
package gpfw_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam logic [1:0] CMD_SET_CURSOR = 2'd0;
  localparam logic [1:0] CMD_GLYPH_ROW  = 2'd1;
  localparam logic [1:0] CMD_FILL       = 2'd2;
  localparam logic [1:0] CMD_READ_BYTE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [CFG_DATA_W-1:0] FONT_HEIGHT_RST = 5'd10;
  localparam logic [4:0]            GLYPH_W_MAX     = 5'd16;

  localparam logic [7:0] FILL_BLACK = 8'h00;
  localparam logic [7:0] FILL_WHITE = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  cursor_x;
    logic [5:0]  cursor_y;
    logic [15:0] glyph_row_bits;
    logic [3:0]  row_index;
    logic        last_row;
    logic        pixel_color;
    logic [9:0]  read_address;
  } cmd_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] font_width;
    logic [CFG_DATA_W-1:0] font_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } res_t;

endpackage

FILE: rtl/core/gpfw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gpfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gpfw_engine.sv
// Command sequencer with the pixel read-modify-write unit, cursor and frame store.
module gpfw_engine #(
  parameter int unsigned SCREEN_WIDTH  = gpfw_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = gpfw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gpfw_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  gpfw_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output gpfw_pkg::res_t res
);
  import gpfw_pkg::*;

  localparam int unsigned STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_GLYPH = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [6:0]    cursor_col_r, cursor_col_nxt;
  logic [5:0]    cursor_row_r, cursor_row_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [7:0]    fill_byte_r, fill_byte_nxt;
  logic [15:0]   bits_r, bits_nxt;
  logic          color_r, color_nxt;
  logic          last_r, last_nxt;
  logic [4:0]    w_r, w_nxt;
  logic [4:0]    lim_r, lim_nxt;
  logic [4:0]    j_r, j_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [7:0]    mask_r, mask_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          pend_white_r, pend_white_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  res_t          res_r, res_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [4:0]    w_clamp;
  logic [8:0]    col_sum;
  logic [7:0]    row_sum;
  logic          no_fit;
  logic [6:0]    y_new;
  logic          y_out;
  logic          rd_in_range;
  logic [AW-1:0] glyph_addr;
  logic          issue;

  gpfw_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign w_clamp     = (cfg.font_width > GLYPH_W_MAX) ? GLYPH_W_MAX : cfg.font_width;
  assign col_sum     = 9'(cursor_col_r) + 9'(w_clamp);
  assign row_sum     = 8'(cursor_row_r) + 8'(cfg.font_height);
  assign no_fit      = (32'(col_sum) >= SCREEN_WIDTH) || (32'(row_sum) >= SCREEN_HEIGHT);
  assign y_new       = 7'(cursor_row_r) + 7'(cmd.row_index);
  assign y_out       = 32'(y_new) >= SCREEN_HEIGHT;
  assign rd_in_range = 32'(cmd.read_address) < STORE_BYTES;
  assign glyph_addr  = base_r + AW'(j_r);
  assign issue       = j_r < lim_r;

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    pend_v_nxt     = pend_v_r;
    fill_byte_nxt  = fill_byte_r;
    bits_nxt       = bits_r;
    color_nxt      = color_r;
    last_nxt       = last_r;
    w_nxt          = w_r;
    lim_nxt        = lim_r;
    j_nxt          = j_r;
    base_nxt       = base_r;
    mask_nxt       = mask_r;
    pend_addr_nxt  = pend_addr_r;
    pend_white_nxt = pend_white_r;
    rd_ok_nxt      = rd_ok_r;
    res_nxt        = res_r;
    ram_we         = 1'b0;
    ram_waddr      = sweep_r;
    ram_wdata      = fill_byte_r;
    ram_raddr      = glyph_addr;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = FILL_BLACK;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = AW'(cmd.read_address);
        if (cmd_valid) begin
          res_nxt = '0;
          case (cmd.cmd)
            CMD_SET_CURSOR: begin
              cursor_col_nxt = cmd.cursor_x;
              cursor_row_nxt = cmd.cursor_y;
              state_nxt      = S_DONE;
            end
            CMD_GLYPH_ROW: begin
              if (no_fit) begin
                res_nxt.status = 1'b1;
                state_nxt      = S_DONE;
              end else begin
                bits_nxt   = cmd.glyph_row_bits;
                color_nxt  = cmd.pixel_color;
                last_nxt   = cmd.last_row;
                w_nxt      = w_clamp;
                lim_nxt    = y_out ? 5'd0 : w_clamp;
                j_nxt      = '0;
                pend_v_nxt = 1'b0;
                base_nxt   = AW'(32'(y_new[6:3]) * SCREEN_WIDTH + 32'(cursor_col_r));
                mask_nxt   = 8'(1) << y_new[2:0];
                state_nxt  = S_GLYPH;
              end
            end
            CMD_FILL: begin
              fill_byte_nxt = cmd.pixel_color ? FILL_WHITE : FILL_BLACK;
              sweep_nxt     = '0;
              state_nxt     = S_FILL;
            end
            CMD_READ_BYTE: begin
              rd_ok_nxt = rd_in_range;
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          state_nxt = S_DONE;
        end
      end
      S_GLYPH: begin
        if (pend_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = pend_white_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
        end
        pend_v_nxt = 1'b0;
        if (issue) begin
          pend_v_nxt     = 1'b1;
          pend_addr_nxt  = glyph_addr;
          pend_white_nxt = bits_r[15] ~^ color_r;
          bits_nxt       = bits_r << 1;
          j_nxt          = j_r + 5'd1;
        end else begin
          if (last_r) begin
            cursor_col_nxt = cursor_col_r + 7'(w_r);
          end
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        res_nxt.read_data = rd_ok_r ? ram_rdata : 8'h00;
        state_nxt         = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      sweep_r      <= '0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      pend_v_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      pend_v_r     <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_byte_r  <= fill_byte_nxt;
    bits_r       <= bits_nxt;
    color_r      <= color_nxt;
    last_r       <= last_nxt;
    w_r          <= w_nxt;
    lim_r        <= lim_nxt;
    j_r          <= j_nxt;
    base_r       <= base_nxt;
    mask_r       <= mask_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_white_r <= pend_white_nxt;
    rd_ok_r      <= rd_ok_nxt;
    res_r        <= res_nxt;
  end

  a_no_write_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_READ || state_r == S_DONE) |-> !ram_we)
    else $error("store written outside a sweep or glyph row");

  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GLYPH && pend_v_r && issue) |-> (ram_raddr != pend_addr_r))
    else $error("glyph read collides with pending write");

  a_glyph_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GLYPH && !issue) |=> !pend_v_r)
    else $error("pixel write left pending after glyph row");

  a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.status) |-> (res_r.read_data == 8'h00))
    else $error("rejected row carries read data");

  a_busy_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !cmd_ready)
    else $error("item taken during store clear");

endmodule

FILE: rtl/core/glyph_page_framebuffer_writer_top.sv
// Top level of the glyph page framebuffer writer: stream ports, font registers, result register.
// Each item yields one result. A glyph row writes min(font_width,16) pixels, one pixel
// read-modify-write per cycle through the single-port-pair frame store, reads and writes of
// adjacent pixels overlapped; a glyph row whose pixel row lies below the screen writes no
// pixel, and a glyph row rejected by the fit check writes nothing. Fill writes one store byte
// per cycle. After reset the store of SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes (1024 by default) is
// cleared one byte per cycle with in_tready low; font register writes are taken meanwhile. A
// finished result waits in the output register while the next item is accepted.
module glyph_page_framebuffer_writer_top #(
  parameter int unsigned SCREEN_WIDTH  = gpfw_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = gpfw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cursor_x[6:0] cursor_y[12:7] glyph_row_bits[28:13] row_index[32:29]
  // pixel_color[33] read_address[43:34] zero[47:44]
  input  logic [gpfw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  logic [1:0]                         in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_data[7:0] status[8] zero[15:9]
  output logic [gpfw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gpfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpfw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gpfw_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  res_t eng_res;
  res_t out_res_r;
  logic eng_res_valid;
  logic res_ready;
  logic out_tvalid_r;

  assign cmd.cmd            = in_tuser;
  assign cmd.cursor_x       = in_tdata[6:0];
  assign cmd.cursor_y       = in_tdata[12:7];
  assign cmd.glyph_row_bits = in_tdata[28:13];
  assign cmd.row_index      = in_tdata[32:29];
  assign cmd.last_row       = in_tlast;
  assign cmd.pixel_color    = in_tdata[33];
  assign cmd.read_address   = in_tdata[43:34];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_width  <= FONT_WIDTH_RST;
      cfg_r.font_height <= FONT_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FONT_WIDTH:  cfg_r.font_width  <= cfg_data;
        CFG_FONT_HEIGHT: cfg_r.font_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gpfw_engine #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(in_tvalid),
    .cmd_ready(in_tready),
    .cmd      (cmd),
    .res_valid(eng_res_valid),
    .res_ready(res_ready),
    .res      (eng_res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && eng_res_valid) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_res_r.status, out_res_r.read_data};

endmodule
